// ===== design/sha1bs_pkg.sv =====
// Shared types, constants and round functions for the SHA-1 byte stream hasher.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package sha1bs_pkg;

  // Default depth of the request queue between the front and the core.
  localparam int QueueDepth = 4;

  // SHA-1 initial chaining words; index 0 is H0.
  localparam logic [4:0][31:0] HInit = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  // Round constants for the four groups of twenty rounds.
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [6:0] LastRound   = 7'd79;
  localparam logic [7:0] PadMarker   = 8'h80;
  localparam logic [5:0] LenFill     = 6'd56;
  localparam logic [5:0] LastFill    = 6'd63;
  localparam logic [2:0] LastWordIdx = 3'd4;

  // One input request as it appears on the input port.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  // One digest word as it appears on the result port.
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // Classified request kinds kept in the queue.
  typedef enum logic [1:0] {
    OP_BYTE,
    OP_BYTE_END,
    OP_END
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] data;
  } op_t;

  // Head of the request queue as the core sees it.
  typedef struct packed {
    logic valid;
    op_t  op;
  } queue_head_t;

  // Finished digest handed from the core to the output unit.
  typedef struct packed {
    logic             valid;
    logic [4:0][31:0] words;
  } digest_req_t;

  typedef enum logic [2:0] {
    CS_LOAD,
    CS_PAD,
    CS_ROUND,
    CS_ADD,
    CS_EMIT
  } core_state_t;

  // Boolean function of a round.
  function automatic logic [31:0] round_f(input logic [6:0] round,
                                          input logic [31:0] b,
                                          input logic [31:0] c,
                                          input logic [31:0] d);
    logic [31:0] res;
    if (round < 7'd20) begin
      res = (b & c) | (~b & d);
    end else if (round < 7'd40) begin
      res = b ^ c ^ d;
    end else if (round < 7'd60) begin
      res = (b & c) | (b & d) | (c & d);
    end else begin
      res = b ^ c ^ d;
    end
    return res;
  endfunction

  // Additive constant of a round.
  function automatic logic [31:0] round_k(input logic [6:0] round);
    logic [31:0] res;
    if (round < 7'd20) begin
      res = K0;
    end else if (round < 7'd40) begin
      res = K1;
    end else if (round < 7'd60) begin
      res = K2;
    end else begin
      res = K3;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== design/sha1_byte_stream_hash.sv =====
// SHA-1 byte stream hasher, top level: front queue, hash core, output unit.
// Depends on sha1bs_pkg, sha1bs_front, sha1bs_core and sha1bs_out.
//
// Usage: the input side is a queue. Each request carries one message byte
// (byte_present), an end mark (end_of_message), both, or neither; a request
// with neither is accepted and ignored. An end mark pads the message and
// yields its 160-bit digest as five result words, word_index 0 to 4, with
// last_word set on word 4. The result side is a queue too: a word waits on
// result while empty is low and leaves when pop is high.
// Throughput: the core takes one byte per cycle from a short request queue
// while loading; every 64th byte starts the 80 rounds, one per cycle, and then
// the chaining add, during which no bytes are taken.
// After the end request reaches the core, padding shifts in one byte per
// cycle (64 - fill bytes, or 128 - fill when fill >= 56 and two blocks are
// hashed), each block runs its rounds and chaining add, then the core enters
// its emit state and the output unit registers the digest for the result port.
// A stalled result side holds the digest; the core keeps hashing the next
// message and stops only when a second digest is ready, after which the
// request queue fills and full rises. Reset (rst, synchronous) empties both
// queues and restarts with the standard initial chaining words.
`default_nettype none

module sha1_byte_stream_hash #(
  parameter int QUEUE_DEPTH = sha1bs_pkg::QueueDepth
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   push,
  output logic                  full,
  input  sha1bs_pkg::in_item_t  item,
  output logic                  empty,
  input  wire                   pop,
  output sha1bs_pkg::out_item_t result
);

  sha1bs_pkg::queue_head_t head;
  logic                    head_pop;
  sha1bs_pkg::digest_req_t digest;
  logic                    digest_ready;

  sha1bs_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (item),
    .head    (head),
    .head_pop(head_pop)
  );

  sha1bs_core u_core (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .head_pop    (head_pop),
    .digest      (digest),
    .digest_ready(digest_ready)
  );

  sha1bs_out u_out (
    .clk         (clk),
    .rst         (rst),
    .digest      (digest),
    .digest_ready(digest_ready),
    .empty       (empty),
    .pop         (pop),
    .result      (result)
  );

endmodule

`default_nettype wire

// ===== design/sha1bs_front.sv =====
// Front end: accepts input requests, drops empty ones, classifies the rest and
// queues them for the core. Depends on sha1bs_pkg.
`default_nettype none

module sha1bs_front #(
  parameter int QUEUE_DEPTH = sha1bs_pkg::QueueDepth
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     push,
  output logic                    full,
  input  sha1bs_pkg::in_item_t    item,
  output sha1bs_pkg::queue_head_t head,
  input  wire                     head_pop
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  sha1bs_pkg::op_t queue [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            keep;
  logic            do_write;
  logic            do_read;
  sha1bs_pkg::op_t op_in;

  // Classify the request; one with neither a byte nor an end mark is dropped.
  always_comb begin
    keep       = item.byte_present | item.end_of_message;
    op_in.data = item.data_byte;
    if (item.byte_present && item.end_of_message) begin
      op_in.kind = sha1bs_pkg::OP_BYTE_END;
    end else if (item.byte_present) begin
      op_in.kind = sha1bs_pkg::OP_BYTE;
    end else begin
      op_in.kind = sha1bs_pkg::OP_END;
    end
  end

  assign full       = (count == CntW'(QUEUE_DEPTH));
  assign do_write   = push & ~full & keep;
  assign do_read    = head_pop & (count != '0);
  assign head.valid = (count != '0);
  assign head.op    = queue[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (do_write) begin
      queue[wr_ptr] <= op_in;
    end
  end

  // Queue pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_write) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_read) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_write && !do_read) begin
        count <= count + 1'b1;
      end else if (!do_write && do_read) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/sha1bs_core.sv =====
// Hash core: shifts message and padding bytes into a 512-bit window, runs the
// 80 rounds one per cycle and keeps the chaining words. Depends on sha1bs_pkg.
`default_nettype none

module sha1bs_core (
  input  wire                     clk,
  input  wire                     rst,
  input  sha1bs_pkg::queue_head_t head,
  output logic                    head_pop,
  output sha1bs_pkg::digest_req_t digest,
  input  wire                     digest_ready
);

  sha1bs_pkg::core_state_t state, state_next;

  logic [511:0]     win;
  logic [5:0]       fill;
  logic [60:0]      byte_cnt;
  logic [63:0]      len;
  logic [4:0][31:0] chain;
  logic [31:0]      a, b, c, d, e;
  logic [6:0]       round;
  logic             pad_marker;
  logic             len_mode;
  logic             end_pend;
  logic             final_blk;

  logic             shift_byte;
  logic [7:0]       byte_in;
  logic             len_byte;
  logic             start_round;
  logic             do_round;
  logic             do_add;
  logic             emit;
  logic             take;
  logic [60:0]      cnt_inc;

  logic [31:0]      w0, w2, w8, w13, w_mix, w_new, t;

  // Message schedule taps: window word j holds w[r + j].
  assign w0    = win[511:480];
  assign w2    = win[447:416];
  assign w8    = win[255:224];
  assign w13   = win[95:64];
  assign w_mix = w13 ^ w8 ^ w2 ^ w0;
  assign w_new = {w_mix[30:0], w_mix[31]};
  assign t     = {a[26:0], a[31:27]} + sha1bs_pkg::round_f(round, b, c, d) + e +
                 sha1bs_pkg::round_k(round) + w0;

  assign cnt_inc = byte_cnt + 61'd1;
  assign take    = (state == sha1bs_pkg::CS_LOAD) & head.valid;

  assign digest.valid = (state == sha1bs_pkg::CS_EMIT);
  assign digest.words = chain;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha1bs_pkg::CS_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath controls.
  always_comb begin
    state_next  = state;
    head_pop    = 1'b0;
    shift_byte  = 1'b0;
    byte_in     = '0;
    len_byte    = 1'b0;
    start_round = 1'b0;
    do_round    = 1'b0;
    do_add      = 1'b0;
    emit        = 1'b0;
    case (state)
      sha1bs_pkg::CS_LOAD: begin
        if (head.valid) begin
          head_pop = 1'b1;
          if (head.op.kind != sha1bs_pkg::OP_END) begin
            shift_byte = 1'b1;
            byte_in    = head.op.data;
          end
          if (head.op.kind != sha1bs_pkg::OP_END && fill == sha1bs_pkg::LastFill) begin
            state_next  = sha1bs_pkg::CS_ROUND;
            start_round = 1'b1;
          end else if (head.op.kind != sha1bs_pkg::OP_BYTE) begin
            state_next = sha1bs_pkg::CS_PAD;
          end
        end
      end
      sha1bs_pkg::CS_PAD: begin
        shift_byte = 1'b1;
        len_byte   = ~pad_marker & (len_mode | (fill == sha1bs_pkg::LenFill));
        if (pad_marker) begin
          byte_in = sha1bs_pkg::PadMarker;
        end else if (len_byte) begin
          byte_in = len[63:56];
        end
        if (fill == sha1bs_pkg::LastFill) begin
          state_next  = sha1bs_pkg::CS_ROUND;
          start_round = 1'b1;
        end
      end
      sha1bs_pkg::CS_ROUND: begin
        do_round = 1'b1;
        if (round == sha1bs_pkg::LastRound) begin
          state_next = sha1bs_pkg::CS_ADD;
        end
      end
      sha1bs_pkg::CS_ADD: begin
        do_add = 1'b1;
        if (final_blk) begin
          state_next = sha1bs_pkg::CS_EMIT;
        end else if (end_pend) begin
          state_next = sha1bs_pkg::CS_PAD;
        end else begin
          state_next = sha1bs_pkg::CS_LOAD;
        end
      end
      sha1bs_pkg::CS_EMIT: begin
        if (digest_ready) begin
          emit       = 1'b1;
          state_next = sha1bs_pkg::CS_LOAD;
        end
      end
      default: begin
        state_next = sha1bs_pkg::CS_LOAD;
      end
    endcase
  end

  // Block window: byte shifts while loading, word shifts while hashing.
  always_ff @(posedge clk) begin
    if (shift_byte) begin
      win <= {win[503:0], byte_in};
    end else if (do_round) begin
      win <= {win[479:0], w_new};
    end
  end

  // Working variables and round counter.
  always_ff @(posedge clk) begin
    if (start_round) begin
      a     <= chain[0];
      b     <= chain[1];
      c     <= chain[2];
      d     <= chain[3];
      e     <= chain[4];
      round <= '0;
    end else if (do_round) begin
      a     <= t;
      b     <= a;
      c     <= {b[1:0], b[31:2]};
      d     <= c;
      e     <= d;
      round <= round + 7'd1;
    end
  end

  // Length register: captured at the end mark, shifted out a byte at a time.
  always_ff @(posedge clk) begin
    if (take && head.op.kind != sha1bs_pkg::OP_BYTE) begin
      len <= (head.op.kind == sha1bs_pkg::OP_BYTE_END) ? {cnt_inc, 3'b000}
                                                       : {byte_cnt, 3'b000};
    end else if (len_byte) begin
      len <= {len[55:0], 8'h00};
    end
  end

  // Control state, fill level, byte count and chaining words.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      byte_cnt   <= '0;
      chain      <= sha1bs_pkg::HInit;
      pad_marker <= 1'b0;
      len_mode   <= 1'b0;
      end_pend   <= 1'b0;
      final_blk  <= 1'b0;
    end else begin
      if (shift_byte) begin
        fill <= fill + 6'd1;
      end
      if (take) begin
        if (head.op.kind == sha1bs_pkg::OP_BYTE) begin
          byte_cnt <= cnt_inc;
        end else begin
          byte_cnt   <= '0;
          end_pend   <= 1'b1;
          pad_marker <= 1'b1;
        end
      end
      if (state == sha1bs_pkg::CS_PAD) begin
        pad_marker <= 1'b0;
        if (len_byte) begin
          len_mode <= 1'b1;
        end
        if (fill == sha1bs_pkg::LastFill) begin
          final_blk <= len_byte;
        end
      end
      if (do_add) begin
        chain[0] <= chain[0] + a;
        chain[1] <= chain[1] + b;
        chain[2] <= chain[2] + c;
        chain[3] <= chain[3] + d;
        chain[4] <= chain[4] + e;
      end
      if (emit) begin
        chain     <= sha1bs_pkg::HInit;
        len_mode  <= 1'b0;
        end_pend  <= 1'b0;
        final_blk <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/sha1bs_out.sv =====
// Output unit: holds one finished digest and presents it as five words on a
// queue-style result port. Depends on sha1bs_pkg.
`default_nettype none

module sha1bs_out (
  input  wire                     clk,
  input  wire                     rst,
  input  sha1bs_pkg::digest_req_t digest,
  output logic                    digest_ready,
  output logic                    empty,
  input  wire                     pop,
  output sha1bs_pkg::out_item_t   result
);

  logic             busy;
  logic [2:0]       idx;
  logic [4:0][31:0] words;

  assign digest_ready = ~busy;
  assign empty        = ~busy;

  // Select the word under the index.
  always_comb begin
    case (idx)
      3'd0:    result.digest_word = words[0];
      3'd1:    result.digest_word = words[1];
      3'd2:    result.digest_word = words[2];
      3'd3:    result.digest_word = words[3];
      3'd4:    result.digest_word = words[4];
      default: result.digest_word = '0;
    endcase
    result.word_index = idx;
    result.last_word  = (idx == sha1bs_pkg::LastWordIdx);
  end

  // Digest holding register.
  always_ff @(posedge clk) begin
    if (digest.valid && !busy) begin
      words <= digest.words;
    end
  end

  // Word index and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (!busy) begin
      if (digest.valid) begin
        busy <= 1'b1;
        idx  <= '0;
      end
    end else if (pop) begin
      if (idx == sha1bs_pkg::LastWordIdx) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/sha1bs_checker.sv =====
// Port-level checks for the SHA-1 byte stream hasher, bound to the top level.
// Depends on sha1bs_pkg and sha1_byte_stream_hash.
`default_nettype none

module sha1bs_checker (
  input wire                   clk,
  input wire                   rst,
  input wire                   empty,
  input wire                   pop,
  input sha1bs_pkg::out_item_t result
);

  // A waiting word always has an index within the digest.
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.word_index == 3'd0 || result.word_index == 3'd1 ||
                result.word_index == 3'd2 || result.word_index == 3'd3 ||
                result.word_index == 3'd4))
    else $error("word_index out of range");

  // The last-word flag marks exactly the fifth word.
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.last_word == (result.word_index == sha1bs_pkg::LastWordIdx)))
    else $error("last_word does not match word_index");

  // Words of one digest follow each other without a gap.
  a_word_seq: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !result.last_word) |=>
      (!empty && result.word_index == $past(result.word_index) + 3'd1))
    else $error("digest words not consecutive");

  // A stalled word holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed");

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result present after reset");

endmodule

bind sha1_byte_stream_hash sha1bs_checker u_chk (.*);

`default_nettype wire
